[hdl/klt_pkg.sv]
// ----------------------------------------------------------------------------
// klt_pkg - shared types and constants for the k-th largest tracker
// Request and response payloads, action codes, cell control and FSM states.
// ----------------------------------------------------------------------------
package klt_pkg;

   // fixed field widths
   localparam int VALUE_W   = 32;
   localparam int RANK_W    = 9;
   localparam int MAX_K_DEF = 256;

   // action codes
   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_QUERY  = 2'd1;
   localparam logic [1:0] ACT_CLEAR  = 2'd2;

   typedef struct packed {
      logic [1:0]                 action;
      logic signed [VALUE_W-1:0]  value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0]  kth_value;
      logic                       valid_res;
   } rsp_type;

   // broadcast control from the sequencer to every cell
   typedef struct packed {
      logic insert;   // place new value, shift smaller ones down
      logic clear;    // drop all entries
      logic load;     // copy entries into the read lane
      logic shift;    // move the read lane one cell toward the head
   } cell_ctl_type;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } klt_state_type;

endpackage

[hdl/klt_cell.sv]
// ----------------------------------------------------------------------------
// klt_cell - one slot of the sorted list
// Holds one value with its valid bit, takes part in the sorted insert and
// carries one word of the read lane.
// ----------------------------------------------------------------------------
module klt_cell
   import klt_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  cell_ctl_type              ctl,
   input  logic signed [VALUE_W-1:0] new_value,
   input  logic signed [VALUE_W-1:0] prev_value,
   input  logic                      prev_valid,
   input  logic                      prev_ins,
   input  logic signed [VALUE_W-1:0] next_rd,
   output logic signed [VALUE_W-1:0] value,
   output logic                      valid,
   output logic                      ins,
   output logic signed [VALUE_W-1:0] rd
);

   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic                      valid_ff, valid_in;
   logic signed [VALUE_W-1:0] rd_ff, rd_in;

   // new value lands here or earlier unless this entry is at least as great
   assign ins = !(valid_ff && (value_ff >= new_value));

   // insert / clear
   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (ctl.clear) begin
         valid_in = 1'b0;
      end else if (ctl.insert && ins) begin
         if (prev_ins) begin
            value_in = prev_value;
            valid_in = prev_valid;
         end else begin
            value_in = new_value;
            valid_in = 1'b1;
         end
      end
   end

   // read lane
   always_comb begin
      rd_in = rd_ff;
      if (ctl.load) begin
         rd_in = value_ff;
      end else if (ctl.shift) begin
         rd_in = next_rd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      rd_ff    <= rd_in;
   end

   assign value = value_ff;
   assign valid = valid_ff;
   assign rd    = rd_ff;

endmodule

[hdl/klt_chain.sv]
// ----------------------------------------------------------------------------
// klt_chain - row of sorted list cells
// Cell 0 holds the greatest value; the read lane drains toward cell 0.
// ----------------------------------------------------------------------------
module klt_chain
   import klt_pkg::*;
#(
   parameter int MAX_K = MAX_K_DEF
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  cell_ctl_type              ctl,
   input  logic signed [VALUE_W-1:0] new_value,
   output logic signed [VALUE_W-1:0] head_rd
);

   logic signed [VALUE_W-1:0] value_w [MAX_K];
   logic signed [VALUE_W-1:0] rd_w    [MAX_K];
   logic                      valid_w [MAX_K];
   logic                      ins_w   [MAX_K];

   for (genvar i = 0; i < MAX_K; i++) begin : g_cell
      logic signed [VALUE_W-1:0] prev_value;
      logic                      prev_valid;
      logic                      prev_ins;
      logic signed [VALUE_W-1:0] next_rd;

      // neighbor hookup; head has no predecessor, tail has no successor
      if (i == 0) begin : g_head
         assign prev_value = '0;
         assign prev_valid = 1'b0;
         assign prev_ins   = 1'b0;
      end else begin : g_body
         assign prev_value = value_w[i-1];
         assign prev_valid = valid_w[i-1];
         assign prev_ins   = ins_w[i-1];
      end

      if (i == MAX_K - 1) begin : g_tail
         assign next_rd = '0;
      end else begin : g_link
         assign next_rd = rd_w[i+1];
      end

      klt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .new_value  (new_value),
         .prev_value (prev_value),
         .prev_valid (prev_valid),
         .prev_ins   (prev_ins),
         .next_rd    (next_rd),
         .value      (value_w[i]),
         .valid      (valid_w[i]),
         .ins        (ins_w[i]),
         .rd         (rd_w[i])
      );
   end

   assign head_rd = rd_w[0];

endmodule

[hdl/kth_largest_tracker_top.sv]
// ----------------------------------------------------------------------------
// kth_largest_tracker_top - k-th greatest value tracker
// Keeps the MAX_K greatest inserted values sorted in a row of cells and
// answers rank queries against the rank_k register.
// ----------------------------------------------------------------------------
//  channel   ports                       direction  handshake
//  request   start, busy, req_payload    in         start && !busy
//  response  rsp_strobe, rsp_payload     out        one-cycle strobe
//  config    csr_wr_en, csr_wr_data      in         write when csr_wr_en
//
//  Insert and clear never raise busy; inserts can arrive every cycle while busy is low.
//  A valid query loads the read lane and drains it toward the head cell while
//  busy stays high, and the response is registered from the head cell as the
//  drain ends; an out-of-range query answers on the next cycle.
//  Reset empties the list and sets rank_k to 1. Responses cannot be stalled.
// ----------------------------------------------------------------------------
module kth_largest_tracker_top
   import klt_pkg::*;
#(
   parameter int MAX_K = MAX_K_DEF
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  req_type           req_payload,
   output logic              rsp_strobe,
   output rsp_type           rsp_payload,
   input  logic              csr_wr_en,
   input  logic [RANK_W-1:0] csr_wr_data
);

   localparam int CNT_W = $clog2(MAX_K + 1);
   localparam int IDX_W = (MAX_K > 1) ? $clog2(MAX_K) : 1;
   localparam int CMP_W = ((CNT_W > RANK_W) ? CNT_W : RANK_W) + 1;

   klt_state_type           state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [IDX_W-1:0]        scan_ff, scan_in;
   logic [RANK_W-1:0]       rank_k_ff;
   logic                    rsp_strobe_ff, rsp_strobe_in;
   rsp_type                 rsp_ff, rsp_in;
   cell_ctl_type            ctl;
   logic signed [VALUE_W-1:0] head_rd;
   logic                    accept;
   logic                    rank_ok;

   assign busy   = (state_ff == ST_SCAN);
   assign accept = start && !busy;

   // rank must be nonzero, tracked and populated
   assign rank_ok = (rank_k_ff != '0)
                 && (CMP_W'(rank_k_ff) <= CMP_W'(MAX_K))
                 && (CMP_W'(rank_k_ff) <= CMP_W'(count_ff));

   // rank register
   always_ff @(posedge clock) begin
      if (reset) begin
         rank_k_ff <= RANK_W'(1);
      end else if (csr_wr_en) begin
         rank_k_ff <= csr_wr_data;
      end
   end

   // sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      rsp_ff  <= rsp_in;
   end

   // next state, cell control and response
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      scan_in       = scan_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      ctl           = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_payload.action)
                  ACT_INSERT: begin
                     ctl.insert = 1'b1;
                     if (count_ff < CNT_W'(MAX_K)) begin
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  ACT_QUERY: begin
                     if (rank_ok) begin
                        ctl.load = 1'b1;
                        scan_in  = IDX_W'(rank_k_ff - RANK_W'(1));
                        state_in = ST_SCAN;
                     end else begin
                        rsp_strobe_in = 1'b1;
                        rsp_in        = '0;
                     end
                  end
                  ACT_CLEAR: begin
                     ctl.clear = 1'b1;
                     count_in  = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (scan_ff == '0) begin
               rsp_strobe_in    = 1'b1;
               rsp_in.kth_value = head_rd;
               rsp_in.valid_res = 1'b1;
               state_in         = ST_IDLE;
            end else begin
               ctl.shift = 1'b1;
               scan_in   = scan_ff - IDX_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   klt_chain #(
      .MAX_K (MAX_K)
   ) u_chain (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .new_value (req_payload.value),
      .head_rd   (head_rd)
   );

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

endmodule
